/* sv/sfb_pkg.sv */
// ----------------------------------------------------------------------------
// sfb_pkg: shared types and constants for the softmax forward/backward core
// Holds the command/status bundles between controller and datapath, the
// fixed field widths and the 2^(-i/16) interpolation table.
// ----------------------------------------------------------------------------
`default_nettype none

package sfb_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int MaxLenDef    = 64;
  localparam int DataWidthDef = 16;

  // Fixed widths of the arithmetic.
  localparam int ResultCap = 64;
  localparam int ProbW     = 16;
  localparam int ExpW      = 17;
  localparam int SumW      = 24;
  localparam int QuotW     = 17;
  localparam int NumW      = 34;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd_elem;
    logic rd_grad;
    logic exp_mul;
    logic exp_int;
    logic exp_shf;
    logic sum_add;
    logic div_start;
    logic f_out;
    logic dot_mul;
    logic dot_acc;
    logic g_dif;
    logic g_mul;
    logic g_out;
    logic idx_inc;
    logic idx_clr;
    logic finish;
  } sfb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_end;
    logic div_busy;
  } sfb_sts_t;

  // 2^(-i/16) in Q16 for i = 0..16.
  function automatic logic [ExpW-1:0] pow2_neg(input logic [4:0] i);
    logic [ExpW-1:0] v;
    unique case (i)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* sv/softmax_forward_backward_core.sv */
// ----------------------------------------------------------------------------
// softmax_forward_backward_core: fixed-point softmax, forward and backward
// Loads a vector, then emits probabilities (forward) or input gradient
// increments (backward) one result at a time.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken at a clock edge where start_i is high and busy_o is low.
// action_i = 0 loads a Q8.8 logit, action_i = 1 an upstream gradient; last_i
// closes the vector and starts the computation. Items without last_i leave
// busy_o low.
// Each result item appears on the output ports for one cycle, marked by
// result_valid_o; there is no way for the receiver to stall it.
// Forward: an exponential pass (read, multiply, interpolate, shift per element)
// builds the sum, then a second pass recomputes each exponential and divides,
// where the restoring divider sets the pace. Backward: a dot product pass,
// then a gradient pass.
// busy_o stays high from the closing item until the last result of the
// vector is registered; the next item can be taken in the cycle that result
// is shown. At most 64 results are emitted per vector.
// Reset clears the load count, the kept forward length and the flags; the
// element stores need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module softmax_forward_backward_core
  import sfb_pkg::*;
#(
  parameter int MAX_LEN    = MaxLenDef,
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic                         action_i,
  input  wire logic signed [DATA_WIDTH-1:0] value_i,
  input  wire logic                         last_i,
  output logic                              result_valid_o,
  output logic                              kind_o,
  output logic [ProbW-1:0]                  probability_o,
  output logic signed [DATA_WIDTH-1:0]      input_grad_o,
  output logic                              end_of_run_o,
  output logic                              length_error_o
);

  sfb_cmd_t cmd;
  sfb_sts_t sts;

  // Sequencer.
  sfb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .last_i   (last_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Stores and arithmetic.
  sfb_dpath #(
    .MAX_LEN    (MAX_LEN),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (action_i),
    .value_i        (value_i),
    .last_i         (last_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .probability_o  (probability_o),
    .input_grad_o   (input_grad_o),
    .end_of_run_o   (end_of_run_o),
    .length_error_o (length_error_o)
  );

  // The final result of a vector leaves the block idle.
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && end_of_run_o |-> !busy_o)
    else $error("block still busy after final result");

  // A closing item always starts a computation.
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && last_i |=> busy_o)
    else $error("closing item did not start the computation");

  // Forward results carry no gradient.
  a_fwd_grad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !kind_o |-> input_grad_o == '0)
    else $error("forward result with nonzero gradient");

  // No result appears without a computation in flight just before.
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result without a running computation");

endmodule

`default_nettype wire

/* sv/sfb_div.sv */
// ----------------------------------------------------------------------------
// sfb_div: restoring divider for the probability quotient
// Produces one quotient bit per cycle. The caller guarantees that the quotient
// fits in 17 bits and holds the divisor while busy.
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_div
  import sfb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NumW-1:0]  num_i,
  input  wire logic [SumW-1:0]  den_i,
  output logic                  busy_o,
  output logic [QuotW-1:0]      quot_o
);

  logic [4:0]       cnt_q, cnt_d;
  logic [SumW-1:0]  rem_q, rem_d;
  logic [QuotW-1:0] nlo_q, nlo_d;
  logic [QuotW-1:0] quo_q, quo_d;
  logic [SumW:0]    trial;
  logic [SumW:0]    diff;
  logic             ge;

  // One restoring step: shift in the next numerator bit and try a subtract.
  always_comb begin
    trial = {rem_q, nlo_q[QuotW-1]};
    diff  = trial - {1'b0, den_i};
    ge    = (trial >= {1'b0, den_i});
    cnt_d = cnt_q;
    rem_d = rem_q;
    nlo_d = nlo_q;
    quo_d = quo_q;
    if (start_i) begin
      cnt_d = 5'(QuotW);
      rem_d = {{(SumW-(NumW-QuotW)){1'b0}}, num_i[NumW-1:QuotW]};
      nlo_d = num_i[QuotW-1:0];
      quo_d = '0;
    end else if (cnt_q != 5'd0) begin
      cnt_d = cnt_q - 5'd1;
      rem_d = ge ? diff[SumW-1:0] : trial[SumW-1:0];
      nlo_d = {nlo_q[QuotW-2:0], 1'b0};
      quo_d = {quo_q[QuotW-2:0], ge};
    end
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Remainder and quotient registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nlo_q <= nlo_d;
    quo_q <= quo_d;
  end

  assign busy_o = (cnt_q != 5'd0);
  assign quot_o = quo_q;

endmodule

`default_nettype wire

/* sv/sfb_dpath.sv */
// ----------------------------------------------------------------------------
// sfb_dpath: datapath of the softmax forward/backward core
// Element, gradient and probability stores, the exponential unit, the sum
// and dot accumulators, the divider and the gradient product with rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_dpath
  import sfb_pkg::*;
#(
  parameter int MAX_LEN    = MaxLenDef,
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire sfb_cmd_t                     cmd_i,
  output sfb_sts_t                          sts_o,
  input  wire logic                         action_i,
  input  wire logic signed [DATA_WIDTH-1:0] value_i,
  input  wire logic                         last_i,
  output logic                              result_valid_o,
  output logic                              kind_o,
  output logic [ProbW-1:0]                  probability_o,
  output logic signed [DATA_WIDTH-1:0]      input_grad_o,
  output logic                              end_of_run_o,
  output logic                              length_error_o
);

  localparam int DW   = DATA_WIDTH;
  localparam int AW   = $clog2(MAX_LEN);
  localparam int CW   = $clog2(MAX_LEN + 1);
  localparam int YW   = (DW + 10 > 22) ? DW + 10 : 22;
  localparam int ACCW = DW + 18 + $clog2(MAX_LEN);
  localparam int DFW  = ACCW + 1;
  localparam int MW   = (DFW > 33) ? DFW : 33;
  localparam int RW   = MW - 15;
  localparam logic [CW-1:0] MaxLenC = CW'(MAX_LEN);
  localparam logic signed [DW-1:0] DataMin = {1'b1, {(DW-1){1'b0}}};
  localparam logic [RW-1:0] GmaxR = {{(RW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic [RW-1:0] GminR = {{(RW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

  // Stores.
  logic signed [DW-1:0] elem_mem [MAX_LEN];
  logic signed [DW-1:0] grad_mem [MAX_LEN];
  logic [ProbW-1:0]     prob_mem [MAX_LEN];

  // Control state.
  logic                 pend_q;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic signed [DW-1:0] max_q, max_d;
  logic [CW-1:0]        n_q;
  logic [CW-1:0]        slen_q;
  logic                 err_q;
  logic [AW-1:0]        idx_q;
  logic [SumW-1:0]      sum_q;
  logic                 ov_q;

  // Payload registers.
  logic signed [DW-1:0]   elem_rd_q, grad_rd_q;
  logic [ProbW-1:0]       prob_rd_q;
  logic [YW-1:0]          y_q;
  logic [ExpW-1:0]        v_q;
  logic                   ksat_q;
  logic [4:0]             k_q;
  logic [ExpW-1:0]        e_q;
  logic signed [DW+16:0]  prod_q;
  logic signed [ACCW-1:0] dot_q;
  logic [ProbW-1:0]       s_q;
  logic                   neg_q;
  logic [MW-1:0]          mag_q;
  logic [MW-17:0]         phi_q;
  logic [47:0]            plo_q;
  logic                   ok_kind_q;
  logic [ProbW-1:0]       ok_prob_q;
  logic signed [DW-1:0]   ok_grad_q;
  logic                   ok_eor_q;
  logic                   ok_err_q;

  // Load: a change of action throws away a partial vector.
  logic            clr;
  logic [CW-1:0]   cnt_eff;
  logic            ovf_eff;
  logic signed [DW-1:0] max_eff;
  logic            room;

  always_comb begin
    clr     = (cnt_q != '0) && (action_i != pend_q);
    cnt_eff = clr ? '0 : cnt_q;
    ovf_eff = clr ? 1'b0 : ovf_q;
    max_eff = clr ? DataMin : max_q;
    room    = (cnt_eff < MaxLenC);
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    max_d   = max_q;
    if (cmd_i.load) begin
      cnt_d = cnt_eff;
      ovf_d = ovf_eff;
      max_d = max_eff;
      if (room) begin
        cnt_d = cnt_eff + CW'(1);
        if (!action_i && (value_i > max_eff)) begin
          max_d = value_i;
        end
      end else begin
        ovf_d = 1'b1;
      end
    end else if (cmd_i.finish) begin
      cnt_d = '0;
      ovf_d = 1'b0;
      max_d = DataMin;
    end
  end

  // Index bookkeeping.
  logic [CW-1:0] idx_ext;
  logic          emit_ok;
  logic          s_valid;

  assign idx_ext = {{(CW-AW){1'b0}}, idx_q};
  assign emit_ok = ({{(32-AW){1'b0}}, idx_q} < 32'(ResultCap));
  assign s_valid = (idx_ext < slen_q);
  assign sts_o.idx_end = (idx_ext == (n_q - CW'(1)));

  // Exponential, step 1: base-2 exponent of the scaled difference.
  logic signed [DW:0] mdiff;
  logic [DW+17:0]     yprod;

  assign mdiff = {max_q[DW-1], max_q} - {elem_rd_q[DW-1], elem_rd_q};
  assign yprod = {18'd0, mdiff[DW-1:0]} * (DW+18)'(94548) + (DW+18)'(128);

  // Exponential, step 2: table lookup with linear interpolation.
  logic [3:0]      t_idx;
  logic [11:0]     t_frac;
  logic [ExpW-1:0] t_a, t_b;
  logic [11:0]     t_d;
  logic [24:0]     t_p;
  logic [YW-1:0]   y_int;

  always_comb begin
    t_idx  = y_q[15:12];
    t_frac = y_q[11:0];
    t_a    = pow2_neg({1'b0, t_idx});
    t_b    = pow2_neg({1'b0, t_idx} + 5'd1);
    t_d    = 12'(t_a - t_b);
    t_p    = {13'd0, t_d} * {13'd0, t_frac} + 25'd2048;
    y_int  = y_q >> 16;
  end

  // Exponential, step 3: integer shift, and the saturating sum.
  logic [ExpW-1:0] e_d;
  logic [SumW:0]   sum_w;

  assign e_d   = ksat_q ? '0 : (v_q >> k_q);
  assign sum_w = {1'b0, sum_q} + {{(SumW+1-ExpW){1'b0}}, e_d};

  // Divider for e * 2^16 / sum, rounded.
  logic [NumW-1:0]  div_num;
  logic [QuotW-1:0] quot;
  logic [ProbW-1:0] prob_sat;

  assign div_num  = {1'b0, e_q, 16'd0} + {11'd0, sum_q[SumW-1:1]};
  assign prob_sat = quot[QuotW-1] ? {ProbW{1'b1}} : quot[ProbW-1:0];

  sfb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (sum_q),
    .busy_o  (sts_o.div_busy),
    .quot_o  (quot)
  );

  // Dot product and gradient difference.
  logic [ProbW-1:0]        s_m;
  logic signed [DFW-1:0]   g_sh, dot_ext, diff;
  logic [DFW-1:0]          mag_w;

  always_comb begin
    s_m     = s_valid ? prob_rd_q : '0;
    g_sh    = {{(DFW-DW-16){grad_rd_q[DW-1]}}, grad_rd_q, 16'd0};
    dot_ext = {dot_q[ACCW-1], dot_q};
    diff    = g_sh - dot_ext;
    mag_w   = diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
  end

  // Rounded product and saturation to the data width.
  logic [48:0]          rnd_w;
  logic [RW-1:0]        rmag;
  logic signed [DW-1:0] gres;

  always_comb begin
    rnd_w = {1'b0, plo_q} + 49'h0_8000_0000;
    rmag  = {1'b0, phi_q} + {{(RW-17){1'b0}}, rnd_w[48:32]};
    if (neg_q) begin
      gres = (rmag > GminR) ? DataMin : DW'((~rmag[DW-1:0]) + DW'(1));
    end else begin
      gres = (rmag > GmaxR) ? {1'b0, {(DW-1){1'b1}}} : rmag[DW-1:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q         <= 1'b0;
      cnt_q          <= '0;
      ovf_q          <= 1'b0;
      max_q          <= DataMin;
      n_q            <= '0;
      slen_q         <= '0;
      err_q          <= 1'b0;
      idx_q          <= '0;
      sum_q          <= '0;
      ov_q           <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      max_q <= max_d;
      if (cmd_i.load) begin
        pend_q <= action_i;
        if (last_i) begin
          n_q   <= cnt_d;
          err_q <= ovf_d | (action_i & (cnt_d != slen_q));
          sum_q <= '0;
        end
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + AW'(1);
      end
      if (cmd_i.sum_add) begin
        sum_q <= sum_w[SumW] ? {SumW{1'b1}} : sum_w[SumW-1:0];
      end
      if (cmd_i.finish && !ov_q) begin
        slen_q <= n_q;
      end
      if (cmd_i.load && last_i) begin
        ov_q <= action_i;
      end
      result_valid_o <= (cmd_i.f_out | cmd_i.g_out) & emit_ok;
    end
  end

  // Stores: written and read with registered read data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      if (!action_i) begin
        elem_mem[cnt_eff[AW-1:0]] <= value_i;
      end else begin
        grad_mem[cnt_eff[AW-1:0]] <= value_i;
      end
    end
    if (cmd_i.rd_elem) begin
      elem_rd_q <= elem_mem[idx_q];
    end
    if (cmd_i.rd_grad) begin
      grad_rd_q <= grad_mem[idx_q];
      prob_rd_q <= prob_mem[idx_q];
    end
    if (cmd_i.f_out) begin
      prob_mem[idx_q] <= prob_sat;
    end
  end

  // Arithmetic pipeline registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && last_i) begin
      dot_q <= '0;
    end
    if (cmd_i.exp_mul) begin
      y_q <= YW'(yprod[DW+17:8]);
    end
    if (cmd_i.exp_int) begin
      v_q    <= t_a - {4'd0, t_p[24:12]};
      ksat_q <= (y_int >= YW'(17));
      k_q    <= y_int[4:0];
    end
    if (cmd_i.exp_shf) begin
      e_q <= e_d;
    end
    if (cmd_i.dot_mul) begin
      prod_q <= $signed({1'b0, s_m}) * grad_rd_q;
    end
    if (cmd_i.dot_acc) begin
      dot_q <= dot_q + {{(ACCW-DW-17){prod_q[DW+16]}}, prod_q};
    end
    if (cmd_i.g_dif) begin
      s_q   <= s_m;
      neg_q <= diff[DFW-1];
      mag_q <= MW'(mag_w);
    end
    if (cmd_i.g_mul) begin
      phi_q <= s_q * mag_q[MW-1:32];
      plo_q <= s_q * mag_q[31:0];
    end
    if (cmd_i.f_out) begin
      ok_kind_q <= 1'b0;
      ok_prob_q <= prob_sat;
      ok_grad_q <= '0;
      ok_eor_q  <= sts_o.idx_end;
      ok_err_q  <= err_q;
    end else if (cmd_i.g_out) begin
      ok_kind_q <= 1'b1;
      ok_prob_q <= s_q;
      ok_grad_q <= gres;
      ok_eor_q  <= sts_o.idx_end;
      ok_err_q  <= err_q;
    end
  end

  assign kind_o         = ok_kind_q;
  assign probability_o  = ok_prob_q;
  assign input_grad_o   = ok_grad_q;
  assign end_of_run_o   = ok_eor_q;
  assign length_error_o = ok_err_q;

endmodule

`default_nettype wire

/* sv/sfb_ctrl.sv */
// ----------------------------------------------------------------------------
// sfb_ctrl: controller of the softmax forward/backward core
// One-hot state machine that sequences loading, the exponential passes,
// the divisions, the dot product pass and the gradient pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_ctrl
  import sfb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire logic     action_i,
  input  wire logic     last_i,
  input  wire sfb_sts_t sts_i,
  output sfb_cmd_t      cmd_o,
  output logic          busy_o
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_E_RD  = 15'b000000000000010,
    S_E_MUL = 15'b000000000000100,
    S_E_INT = 15'b000000000001000,
    S_E_SHF = 15'b000000000010000,
    S_F_DST = 15'b000000000100000,
    S_F_DWT = 15'b000000001000000,
    S_F_OUT = 15'b000000010000000,
    S_D_RD  = 15'b000000100000000,
    S_D_MUL = 15'b000001000000000,
    S_D_ACC = 15'b000010000000000,
    S_G_RD  = 15'b000100000000000,
    S_G_DIF = 15'b001000000000000,
    S_G_MUL = 15'b010000000000000,
    S_G_OUT = 15'b100000000000000
  } sfb_state_e;

  sfb_state_e state_q, state_d;
  logic       pass_q, pass_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (last_i) begin
            cmd_o.idx_clr = 1'b1;
            pass_d        = 1'b0;
            state_d       = action_i ? S_D_RD : S_E_RD;
          end
        end
      end
      S_E_RD: begin
        cmd_o.rd_elem = 1'b1;
        state_d       = S_E_MUL;
      end
      S_E_MUL: begin
        cmd_o.exp_mul = 1'b1;
        state_d       = S_E_INT;
      end
      S_E_INT: begin
        cmd_o.exp_int = 1'b1;
        state_d       = S_E_SHF;
      end
      S_E_SHF: begin
        cmd_o.exp_shf = 1'b1;
        if (pass_q) begin
          state_d = S_F_DST;
        end else begin
          cmd_o.sum_add = 1'b1;
          state_d       = S_E_RD;
          if (sts_i.idx_end) begin
            cmd_o.idx_clr = 1'b1;
            pass_d        = 1'b1;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      S_F_DST: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_F_DWT;
      end
      S_F_DWT: begin
        if (!sts_i.div_busy) begin
          state_d = S_F_OUT;
        end
      end
      S_F_OUT: begin
        cmd_o.f_out = 1'b1;
        if (sts_i.idx_end) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_E_RD;
        end
      end
      S_D_RD: begin
        cmd_o.rd_grad = 1'b1;
        state_d       = S_D_MUL;
      end
      S_D_MUL: begin
        cmd_o.dot_mul = 1'b1;
        state_d       = S_D_ACC;
      end
      S_D_ACC: begin
        cmd_o.dot_acc = 1'b1;
        state_d       = S_D_RD;
        if (sts_i.idx_end) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_G_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_G_RD: begin
        cmd_o.rd_grad = 1'b1;
        state_d       = S_G_DIF;
      end
      S_G_DIF: begin
        cmd_o.g_dif = 1'b1;
        state_d     = S_G_MUL;
      end
      S_G_MUL: begin
        cmd_o.g_mul = 1'b1;
        state_d     = S_G_OUT;
      end
      S_G_OUT: begin
        cmd_o.g_out = 1'b1;
        if (sts_i.idx_end) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_G_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for softmax_forward_backward_core
// Loads forward and backward vectors with random idling, predicts every
// probability and gradient item in fixed point and checks each result field.
// ----------------------------------------------------------------------------
module testbench;
  import sfb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxLen = 64;
  localparam bit ActForward  = 1'b0;
  localparam bit ActBackward = 1'b1;

  typedef struct {
    bit              action;
    bit signed [15:0] value;
    bit              last;
  } load_item_t;

  typedef struct {
    bit        kind;
    bit [15:0] probability;
    bit [15:0] input_grad;
    bit        end_of_run;
    bit        length_error;
  } sm_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic action_i = 1'b0;
  logic signed [15:0] value_i = '0;
  logic last_i = 1'b0;
  logic busy_o, result_valid_o, kind_o, end_of_run_o, length_error_o;
  logic [15:0] probability_o;
  logic signed [15:0] input_grad_o;

  softmax_forward_backward_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .action_i, .value_i, .last_i,
    .result_valid_o, .kind_o, .probability_o, .input_grad_o,
    .end_of_run_o, .length_error_o
  );

  always #2 clk_i = ~clk_i;

  load_item_t  pending_items[$];
  sm_result_t  expected_results[$];
  int          mismatches = 0;
  int          sent_count = 0;
  bit          taken = 1'b0;

  // Shadow state of the core.
  int          elem_mem[MaxLen];
  int          grad_mem[MaxLen];
  int unsigned prob_mem[MaxLen];
  int          load_count = 0;
  int          kept_length = 0;
  int          peak = -32768;
  bit          overflowed = 1'b0;
  bit          pending_action = 1'b0;

  const int unsigned pow2_tab[17] = '{65536, 62757, 60097, 57549, 55109, 52773,
    50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

  // exp(-m/256) in Q1.16 through base-2 table interpolation.
  function automatic longint unsigned exp_term(longint unsigned m);
    longint unsigned y, k, f, idx, r, a, b, v;
    y   = (m * 94548 + 128) >> 8;
    k   = y >> 16;
    f   = y & 16'hFFFF;
    idx = f >> 12;
    r   = f & 12'hFFF;
    a   = pow2_tab[idx];
    b   = pow2_tab[idx + 1];
    v   = a - (((a - b) * r + 2048) >> 12);
    if (k >= 17) return 0;
    return v >> k;
  endfunction

  // Append one input item to the stimulus queue.
  task automatic queue_load(bit act, bit signed [15:0] val, bit lst);
    load_item_t it;
    it.action = act;
    it.value  = val;
    it.last   = lst;
    pending_items.insert(pending_items.size(), it);
  endtask

  // Advance the shadow state by one accepted item and queue its results.
  task automatic predict_softmax(load_item_t it);
    sm_result_t r;
    longint unsigned sum, e, p, s, mag, phi, plo, rmag;
    longint dot, diff, res;
    bit err;
    int n;
    if (load_count > 0 && it.action != pending_action) begin
      load_count = 0; overflowed = 0; peak = -32768;
    end
    pending_action = it.action;
    if (load_count < MaxLen) begin
      if (it.action == ActForward) begin
        elem_mem[load_count] = it.value;
        if (it.value > peak) peak = it.value;
      end else begin
        grad_mem[load_count] = it.value;
      end
      load_count++;
    end else begin
      overflowed = 1;
    end
    if (!it.last) return;
    n = load_count;
    err = overflowed;
    if (it.action == ActForward) begin
      sum = 0;
      for (int i = 0; i < n; i++) begin
        sum += exp_term(peak - elem_mem[i]);
        if (sum > 24'hFFFFFF) sum = 24'hFFFFFF;
      end
      for (int i = 0; i < n; i++) begin
        e = exp_term(peak - elem_mem[i]);
        p = (e * 65536 + sum / 2) / sum;
        if (p > 65535) p = 65535;
        prob_mem[i] = 32'(p);
        r = '{1'b0, p[15:0], 16'd0, i + 1 == n, err};
        expected_results.insert(expected_results.size(), r);
      end
      kept_length = n;
    end else begin
      if (n != kept_length) err = 1;
      dot = 0;
      for (int i = 0; i < n; i++)
        if (i < kept_length) dot += longint'(prob_mem[i]) * grad_mem[i];
      for (int i = 0; i < n; i++) begin
        s = (i < kept_length) ? prob_mem[i] : 0;
        diff = longint'(grad_mem[i]) * 65536 - dot;
        mag = (diff < 0) ? -diff : diff;
        phi = s * (mag >> 32);
        plo = s * (mag & 32'hFFFFFFFF);
        rmag = phi + ((plo + 32'h80000000) >> 32);
        if (diff < 0) res = (rmag > 32768) ? -32768 : -longint'(rmag);
        else          res = (rmag > 32767) ? 32767 : longint'(rmag);
        r = '{1'b1, s[15:0], res[15:0], i + 1 == n, err};
        expected_results.insert(expected_results.size(), r);
      end
    end
    load_count = 0; overflowed = 0; peak = -32768;
  endtask

  // Monitor: take accepted items into the predictor, check each result.
  always @(posedge clk_i) begin
    sm_result_t exp_r;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        predict_softmax('{action_i, value_i, last_i});
        taken = 1'b1;
      end
      if (result_valid_o) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Result item with nothing expected");
        end else begin
          exp_r = expected_results.pop_front();
          if (kind_o !== exp_r.kind || probability_o !== exp_r.probability ||
              input_grad_o !== exp_r.input_grad || end_of_run_o !== exp_r.end_of_run ||
              length_error_o !== exp_r.length_error) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected kind %0d prob %0d grad %0d eor %0d err %0d, got %0d %0d %0d %0d %0d",
                       exp_r.kind, exp_r.probability, $signed(exp_r.input_grad),
                       exp_r.end_of_run, exp_r.length_error, kind_o, probability_o,
                       input_grad_o, end_of_run_o, length_error_o);
          end
        end
      end
    end
  end

  // Driver: hold the current item until taken, idle at random between items.
  always @(negedge clk_i) begin
    load_item_t it;
    if (rst_ni && (!start_i || taken)) begin
      taken = 1'b0;
      if (pending_items.size() > 0 &&
          ((sent_count >= 40 && sent_count < 80) || $urandom_range(99) >= 36)) begin
        it = pending_items.pop_front();
        start_i  <= 1'b1;
        action_i <= it.action;
        value_i  <= it.value;
        last_i   <= it.last;
        sent_count++;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Random element value, often close to the others so that terms matter.
  function automatic bit signed [15:0] rand_value();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(255) - 128);
      2:       return 16'($urandom_range(2047) - 1024);
      default: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  task automatic add_vector(bit action, int len, bit signed [15:0] fixed_val = 0,
                            bit use_fixed = 0);
    for (int i = 0; i < len; i++)
      queue_load(action, use_fixed ? fixed_val : rand_value(), i == len - 1);
  endtask

  initial begin
    int len;
    // Directed part: backward before any forward, single element, extremes,
    // matched and mismatched backward, and an action switch mid-vector.
    add_vector(ActBackward, 2);
    add_vector(ActForward, 1);
    queue_load(ActForward, 16'sh7FFF, 1'b0);
    queue_load(ActForward, 16'sh8000, 1'b0);
    queue_load(ActForward, 16'sh0000, 1'b1);
    queue_load(ActBackward, 16'sh7FFF, 1'b0);
    queue_load(ActBackward, 16'sh8000, 1'b0);
    queue_load(ActBackward, 16'sh0000, 1'b1);
    add_vector(ActForward, 4, 16'sh0100, 1);
    add_vector(ActBackward, 4, 16'sh8000, 1);
    add_vector(ActBackward, 3);
    add_vector(ActForward, 2);
    queue_load(ActBackward, 16'sh0042, 1'b0);
    add_vector(ActForward, 3);
    // Random part: mostly forward then matching backward, some noise.
    while (pending_items.size() < 40) begin
      len = $urandom_range(8, 1);
      add_vector(ActForward, len);
      case ($urandom_range(9))
        0:       add_vector(ActBackward, $urandom_range(8, 1));
        1:       queue_load(ActForward, rand_value(), 1'b0);
        default: add_vector(ActBackward, len);
      endcase
    end
    // Overflow past the store size, then a backward against it.
    add_vector(ActForward, 65);
    add_vector(ActBackward, 3);
    add_vector(ActForward, 5);
    add_vector(ActBackward, 5);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    wait (pending_items.size() == 0 && (!start_i || taken));
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* filelist.f */
sv/sfb_pkg.sv
sv/sfb_div.sv
sv/sfb_dpath.sv
sv/sfb_ctrl.sv
sv/softmax_forward_backward_core.sv
tb/testbench.sv
